// ===== hw/rtl/brk4_pkg.sv =====
//------------------------------------------------------------------------------
// brk4_pkg
// Shared types, constants and register indexes for the Bloch RK4 block.
//------------------------------------------------------------------------------
package brk4_pkg;

	localparam int FRAC_BITS = 30;
	localparam int W         = 32;
	localparam int NCFG      = 8;
	localparam int IDX_W     = 3;

	localparam logic [IDX_W-1:0] REG_RABI   = 3'd0;
	localparam logic [IDX_W-1:0] REG_DETUNE = 3'd1;
	localparam logic [IDX_W-1:0] REG_DECAY  = 3'd2;
	localparam logic [IDX_W-1:0] REG_RELAX  = 3'd3;
	localparam logic [IDX_W-1:0] REG_GREST  = 3'd4;
	localparam logic [IDX_W-1:0] REG_KEEP   = 3'd5;
	localparam logic [IDX_W-1:0] REG_CCOS   = 3'd6;
	localparam logic [IDX_W-1:0] REG_CSIN   = 3'd7;

	localparam logic CMD_RK4   = 1'b0;
	localparam logic CMD_DECAY = 1'b1;

	// wide accumulator: sums of a few shifted 64-bit products
	localparam int ACC_W = 72;

	typedef logic signed [W-1:0]     word_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	// one multiply-accumulate micro-op
	typedef struct packed {
		logic [3:0] a_sel;
		logic [3:0] b_sel;
		logic       neg;
		logic       half;
		logic       dbl;
	} mop_t;

	localparam logic signed [63:0] ONE_FULL = 64'sd1 <<< FRAC_BITS;

	function automatic word_t sat32(input acc_t v);
		acc_t hi;
		acc_t lo;
		hi = acc_t'(32'sh7fffffff);
		lo = -acc_t'(64'sh80000000);
		if (v > hi)
			return word_t'(32'sh7fffffff);
		else if (v < lo)
			return word_t'(32'sh80000000);
		else
			return word_t'(v[W-1:0]);
	endfunction

	function automatic word_t one_val();
		return sat32(acc_t'(ONE_FULL));
	endfunction

endpackage

// ===== hw/rtl/brk4_if.sv =====
//------------------------------------------------------------------------------
// brk4 channel interfaces
// Valid/ready channels for input items, results and configuration writes.
//------------------------------------------------------------------------------
interface brk4_in_if import brk4_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  cmd;
	word_t cos_phase;
	word_t sin_phase;
	modport source (output valid, cmd, cos_phase, sin_phase, input ready);
	modport sink   (input valid, cmd, cos_phase, sin_phase, output ready);
endinterface

interface brk4_out_if import brk4_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t ground_out;
	word_t excited_out;
	word_t coh_real_out;
	word_t coh_imag_out;
	word_t pop_sum;
	modport source (output valid, ground_out, excited_out, coh_real_out, coh_imag_out,
		pop_sum, input ready);
	modport sink   (input valid, ground_out, excited_out, coh_real_out, coh_imag_out,
		pop_sum, output ready);
endinterface

interface brk4_cfg_if import brk4_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	word_t            data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/brk4_mac.sv =====
//------------------------------------------------------------------------------
// brk4_mac
// Shared 32x32 multiplier with floor shift and a wide accumulator.
// Product registered, then shifted (optionally halved, doubled or negated) and accumulated.
//------------------------------------------------------------------------------
module brk4_mac import brk4_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  logic  clr,
	input  word_t a,
	input  word_t b,
	input  logic  neg,
	input  logic  half,
	input  logic  dbl,
	output acc_t  acc
);
	logic signed [63:0] prod_s1;
	logic               neg_s1, half_s1, dbl_s1, vld_s1;
	acc_t               acc_q;
	acc_t               term;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
		neg_s1  <= neg;
		half_s1 <= half;
		dbl_s1  <= dbl;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_comb begin
		term = acc_t'(prod_s1 >>> FRAC_BITS);
		if (half_s1)
			term = term >>> 1;
		if (dbl_s1)
			term = term <<< 1;
		if (neg_s1)
			term = -term;
	end

	always_ff @(posedge clk) begin
		if (clr)
			acc_q <= '0;
		else if (vld_s1)
			acc_q <= acc_q + term;
	end

	assign acc = acc_q;
endmodule

// ===== hw/rtl/bloch_rk4_pulse_decay_step.sv =====
//------------------------------------------------------------------------------
// bloch_rk4_pulse_decay_step
// Two-level optical Bloch stepper: RK4 under a pulse, or analytic free decay.
//------------------------------------------------------------------------------
// One input transaction yields one result transaction. Every product runs
// through one shared 32x32 multiplier with a registered product, sequenced
// by a micro-op program; an accumulate group issues its multiplies and then
// passes the drain states DRN1 and DRN2. An RK4 item (cmd 0) runs four slope
// evaluations of 17 multiplies in six groups, each followed by a stage
// update, then a floor divide by six, one lane at a time. A free decay item
// (cmd 1) runs 6 multiplies in four groups. The next item is accepted only
// after the result of the previous one has been taken. Input ready is low
// while an item is in work and while its result waits. Configuration writes
// are taken only while idle, and a pending write holds off the input.
//------------------------------------------------------------------------------
module bloch_rk4_pulse_decay_step import brk4_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	brk4_in_if.sink    in_ch,
	brk4_out_if.source out_ch,
	brk4_cfg_if.sink   cfg_ch
);
	// operand select codes
	localparam logic [3:0] OP_R   = 4'd0;
	localparam logic [3:0] OP_W   = 4'd1;
	localparam logic [3:0] OP_D   = 4'd2;
	localparam logic [3:0] OP_G   = 4'd3;
	localparam logic [3:0] OP_C   = 4'd4;
	localparam logic [3:0] OP_S   = 4'd5;
	localparam logic [3:0] OP_TG  = 4'd6;
	localparam logic [3:0] OP_TE  = 4'd7;
	localparam logic [3:0] OP_TR  = 4'd8;
	localparam logic [3:0] OP_TI  = 4'd9;
	localparam logic [3:0] OP_U   = 4'd10;
	localparam logic [3:0] OP_EG  = 4'd11;
	localparam logic [3:0] OP_RV  = 4'd12;
	localparam logic [3:0] OP_GG  = 4'd13;
	localparam logic [3:0] OP_KP  = 4'd14;
	localparam logic [3:0] OP_LS  = 4'd15;

	// states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ISS  = 3'd1;
	localparam logic [2:0] ST_DRN1 = 3'd2;
	localparam logic [2:0] ST_DRN2 = 3'd3;
	localparam logic [2:0] ST_STG  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_DIV  = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	// divide by six: 2^16 = 6*10922 + 4, remainder part by reciprocal 2^24/6
	localparam logic [31:0] DIV6_Q = 32'd10922;
	localparam logic [21:0] DIV6_M = 22'd2796203;

	// RK4 slope program: groups end where a value is stored
	// group 0: u ; 1: rv ; 2: k0 ; 3: k1 ; 4: k2 ; 5: k3
	localparam int OPC_W = 5;

	function automatic mop_t rk_op(input logic [OPC_W-1:0] i);
		mop_t m;
		m = '{a_sel: OP_TI, b_sel: OP_C, neg: 1'b0, half: 1'b0, dbl: 1'b0};
		case (i)
			5'd0:  m = '{OP_TI, OP_C,  1'b0, 1'b0, 1'b0};
			5'd1:  m = '{OP_TR, OP_S,  1'b1, 1'b0, 1'b0};
			5'd2:  m = '{OP_R,  OP_EG, 1'b0, 1'b0, 1'b0};
			5'd3:  m = '{OP_R,  OP_U,  1'b0, 1'b0, 1'b1};
			5'd4:  m = '{OP_D,  OP_TE, 1'b0, 1'b0, 1'b0};
			5'd5:  m = '{OP_GG, OP_G,  1'b1, 1'b0, 1'b0};
			5'd6:  m = '{OP_R,  OP_U,  1'b1, 1'b0, 1'b1};
			5'd7:  m = '{OP_D,  OP_TE, 1'b1, 1'b0, 1'b0};
			5'd8:  m = '{OP_TE, OP_G,  1'b1, 1'b0, 1'b0};
			5'd9:  m = '{OP_W,  OP_TI, 1'b1, 1'b0, 1'b0};
			5'd10: m = '{OP_RV, OP_S,  1'b1, 1'b0, 1'b0};
			5'd11: m = '{OP_D,  OP_TR, 1'b1, 1'b1, 1'b0};
			5'd12: m = '{OP_TR, OP_G,  1'b1, 1'b0, 1'b0};
			5'd13: m = '{OP_W,  OP_TR, 1'b0, 1'b0, 1'b0};
			5'd14: m = '{OP_RV, OP_C,  1'b0, 1'b0, 1'b0};
			5'd15: m = '{OP_D,  OP_TI, 1'b1, 1'b1, 1'b0};
			5'd16: m = '{OP_TI, OP_G,  1'b1, 1'b0, 1'b0};
			default: m = '{OP_TI, OP_C, 1'b0, 1'b0, 1'b0};
		endcase
		return m;
	endfunction

	// last op index of each group; decay uses groups 0..3
	function automatic logic [OPC_W-1:0] grp_end(input logic [2:0] gi, input logic dec);
		logic [OPC_W-1:0] r;
		r = '0;
		if (dec) begin
			case (gi)
				3'd0:    r = 5'd0;
				3'd1:    r = 5'd1;
				3'd2:    r = 5'd3;
				default: r = 5'd5;
			endcase
		end else begin
			case (gi)
				3'd0:    r = 5'd1;
				3'd1:    r = 5'd2;
				3'd2:    r = 5'd5;
				3'd3:    r = 5'd8;
				3'd4:    r = 5'd12;
				default: r = 5'd16;
			endcase
		end
		return r;
	endfunction

	function automatic mop_t dec_op(input logic [OPC_W-1:0] i);
		mop_t m;
		m = '{OP_TE, OP_LS, 1'b0, 1'b0, 1'b0};
		case (i)
			5'd0:    m = '{OP_TE, OP_LS, 1'b0, 1'b0, 1'b0};
			5'd1:    m = '{OP_TE, OP_KP, 1'b0, 1'b0, 1'b0};
			5'd2:    m = '{OP_TR, OP_C,  1'b0, 1'b0, 1'b0};
			5'd3:    m = '{OP_TI, OP_S,  1'b1, 1'b0, 1'b0};
			5'd4:    m = '{OP_TR, OP_S,  1'b0, 1'b0, 1'b0};
			default: m = '{OP_TI, OP_C,  1'b0, 1'b0, 1'b0};
		endcase
		return m;
	endfunction

	word_t cfg_q [NCFG];
	word_t st_q [4];
	word_t tmp_q [4];
	word_t k_q [4][4];
	word_t cos_q, sin_q;
	word_t u_q, eg_q, rv_q, gg_q, ls_q;
	logic  cmd_q;
	logic [2:0] state_q;
	logic [OPC_W-1:0] op_q;
	logic [2:0] grp_q;
	logic [1:0] stage_q;
	logic [1:0] lane_q;
	logic [1:0] div_ph_q;
	logic       start_q;
	acc_t       acc;
	mop_t       cur;
	word_t      opa, opb;
	word_t      res_q [5];
	logic       mac_start, mac_clr;
	acc_t       comb_sum, comb_abs;
	logic [33:0] num_q;
	logic        neg_q;
	logic [31:0] quo_q;
	logic [20:0] div_t;
	logic [42:0] div_p;
	logic [31:0] quo;

	assign cfg_ch.ready = (state_q == ST_IDLE);
	assign in_ch.ready  = (state_q == ST_IDLE) && !cfg_ch.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= '0;
			cfg_q[1] <= '0;
			cfg_q[2] <= '0;
			cfg_q[3] <= '0;
			cfg_q[4] <= 32'sd1073741824;
			cfg_q[5] <= 32'sd1073741824;
			cfg_q[6] <= 32'sd1073741824;
			cfg_q[7] <= '0;
		end else if (cfg_ch.valid && cfg_ch.ready) begin
			if (cfg_ch.index == REG_KEEP)
				cfg_q[REG_KEEP] <= {1'b0, cfg_ch.data[W-2:0]};
			else
				cfg_q[cfg_ch.index] <= cfg_ch.data;
		end
	end

	assign cur = cmd_q ? dec_op(op_q) : rk_op(op_q);

	function automatic word_t pick(input logic [3:0] sel, input word_t r, input word_t wd,
		input word_t d, input word_t g, input word_t c, input word_t s, input word_t tg,
		input word_t te, input word_t tr, input word_t ti, input word_t u, input word_t eg,
		input word_t rv, input word_t gg, input word_t kp, input word_t ls);
		word_t v;
		v = '0;
		case (sel)
			OP_R:    v = r;
			OP_W:    v = wd;
			OP_D:    v = d;
			OP_G:    v = g;
			OP_C:    v = c;
			OP_S:    v = s;
			OP_TG:   v = tg;
			OP_TE:   v = te;
			OP_TR:   v = tr;
			OP_TI:   v = ti;
			OP_U:    v = u;
			OP_EG:   v = eg;
			OP_RV:   v = rv;
			OP_GG:   v = gg;
			OP_KP:   v = kp;
			default: v = ls;
		endcase
		return v;
	endfunction

	word_t cc, cs;
	assign cc = cmd_q ? cfg_q[REG_CCOS] : cos_q;
	assign cs = cmd_q ? cfg_q[REG_CSIN] : sin_q;

	assign opa = pick(cur.a_sel, cfg_q[REG_RABI], cfg_q[REG_DETUNE], cfg_q[REG_DECAY],
		cfg_q[REG_RELAX], cc, cs, tmp_q[0], tmp_q[1], tmp_q[2], tmp_q[3], u_q, eg_q, rv_q,
		gg_q, cfg_q[REG_KEEP], ls_q);
	assign opb = pick(cur.b_sel, cfg_q[REG_RABI], cfg_q[REG_DETUNE], cfg_q[REG_DECAY],
		cfg_q[REG_RELAX], cc, cs, tmp_q[0], tmp_q[1], tmp_q[2], tmp_q[3], u_q, eg_q, rv_q,
		gg_q, cfg_q[REG_KEEP], ls_q);

	assign mac_start = (state_q == ST_ISS);
	assign mac_clr   = start_q;

	brk4_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mac_start),
		.clr   (mac_clr),
		.a     (opa),
		.b     (opb),
		.neg   (cur.neg),
		.half  (cur.half),
		.dbl   (cur.dbl),
		.acc   (acc)
	);

	// RK4 combination for one lane; magnitude biased for a floor divide by 6
	always_comb begin
		comb_sum = acc_t'(k_q[0][lane_q]) + (acc_t'(k_q[1][lane_q]) <<< 1)
			+ (acc_t'(k_q[2][lane_q]) <<< 1) + acc_t'(k_q[3][lane_q]);
		comb_abs = (comb_sum < 0) ? (-comb_sum + acc_t'(5)) : comb_sum;
	end

	// num = hi*2^16 + lo: num/6 = hi*10922 + (4*hi + lo)/6
	always_comb begin
		div_t = {1'b0, num_q[33:16], 2'b00} + 21'(num_q[15:0]);
		div_p = 43'(div_t) * 43'(DIV6_M);
		quo   = 32'(num_q[33:16]) * DIV6_Q + 32'(div_p[42:24]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= '0;
			grp_q    <= '0;
			stage_q  <= '0;
			lane_q   <= '0;
			div_ph_q <= '0;
			start_q  <= 1'b0;
			st_q[0]  <= one_val();
			st_q[1]  <= '0;
			st_q[2]  <= '0;
			st_q[3]  <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						cmd_q   <= in_ch.cmd;
						cos_q   <= in_ch.cos_phase;
						sin_q   <= in_ch.sin_phase;
						tmp_q   <= st_q;
						op_q    <= '0;
						grp_q   <= '0;
						stage_q <= '0;
						start_q <= 1'b1;
						eg_q    <= sat32(acc_t'(st_q[1]) - acc_t'(st_q[0]));
						gg_q    <= sat32(acc_t'(st_q[0]) - acc_t'(cfg_q[REG_GREST]));
						ls_q    <= sat32(acc_t'(one_val()) - acc_t'(cfg_q[REG_KEEP]));
						state_q <= ST_ISS;
					end
				end
				ST_ISS: begin
					if (op_q == grp_end(grp_q, cmd_q))
						state_q <= ST_DRN1;
					op_q <= op_q + 1'b1;
				end
				ST_DRN1: state_q <= ST_DRN2;
				ST_DRN2: begin
					start_q <= 1'b1;
					state_q <= ST_ISS;
					grp_q   <= grp_q + 1'b1;
					if (cmd_q) begin
						case (grp_q)
							3'd0: res_q[0] <= sat32(acc_t'(st_q[0]) + acc);
							3'd1: res_q[1] <= sat32(acc);
							3'd2: res_q[2] <= sat32(acc);
							default: begin
								res_q[3] <= sat32(acc);
								state_q  <= ST_OUT;
							end
						endcase
					end else begin
						case (grp_q)
							3'd0: u_q  <= sat32(acc);
							3'd1: rv_q <= sat32(acc);
							3'd2: k_q[stage_q][0] <= sat32(acc);
							3'd3: k_q[stage_q][1] <= sat32(acc);
							3'd4: k_q[stage_q][2] <= sat32(acc);
							default: begin
								k_q[stage_q][3] <= sat32(acc);
								start_q <= 1'b0;
								state_q <= ST_STG;
							end
						endcase
					end
				end
				ST_STG: begin
					for (int j = 0; j < 4; j++) begin
						if (stage_q == 2'd2)
							tmp_q[j] <= sat32(acc_t'(st_q[j]) + acc_t'(k_q[2][j]));
						else
							tmp_q[j] <= sat32(acc_t'(st_q[j])
								+ acc_t'(k_q[stage_q][j] >>> 1));
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (stage_q == 2'd3) begin
						lane_q   <= '0;
						div_ph_q <= '0;
						state_q  <= ST_DIV;
					end else begin
						eg_q    <= sat32(acc_t'(tmp_q[1]) - acc_t'(tmp_q[0]));
						gg_q    <= sat32(acc_t'(tmp_q[0]) - acc_t'(cfg_q[REG_GREST]));
						stage_q <= stage_q + 1'b1;
						op_q    <= '0;
						grp_q   <= '0;
						start_q <= 1'b1;
						state_q <= ST_ISS;
					end
				end
				ST_DIV: begin
					case (div_ph_q)
						2'd0: begin
							num_q    <= comb_abs[33:0];
							neg_q    <= (comb_sum < 0);
							div_ph_q <= 2'd1;
						end
						2'd1: begin
							quo_q    <= quo;
							div_ph_q <= 2'd2;
						end
						default: begin
							res_q[lane_q] <= sat32(acc_t'(st_q[lane_q])
								+ (neg_q ? -acc_t'(quo_q) : acc_t'(quo_q)));
							div_ph_q <= 2'd0;
							lane_q   <= lane_q + 1'b1;
							if (lane_q == 2'd3)
								state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (!out_ch.valid) begin
						for (int j = 0; j < 4; j++)
							st_q[j] <= res_q[j];
						res_q[4] <= sat32(acc_t'(res_q[0]) + acc_t'(res_q[1]));
						out_ch.valid <= 1'b1;
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.ground_out   = res_q[0];
	assign out_ch.excited_out  = res_q[1];
	assign out_ch.coh_real_out = res_q[2];
	assign out_ch.coh_imag_out = res_q[3];
	assign out_ch.pop_sum      = res_q[4];
endmodule

// ===== hw/rtl/brk4_checker.sv =====
//------------------------------------------------------------------------------
// brk4_props
// Port-level checks on the Bloch RK4 block, bound to the top level.
//------------------------------------------------------------------------------
module brk4_props (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while result pending");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("ready after accept");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind bloch_rk4_pulse_decay_step brk4_props u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_ch.valid),
	.in_ready (in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready)
);
